FILE: hdl/wqf_pkg.sv
// Package for the windowed quadratic fit unit: widths, state and register-file
// codes, and the micro-program run by the shared arithmetic sequencer.
// No dependencies.
`default_nettype none

package wqf_pkg;

    localparam int WIDE          = 256;
    localparam int STORE_DEPTH_D = 32;
    localparam int POS_W         = 24;
    localparam int INT_W         = 16;
    localparam int WLEN_W        = 6;
    localparam int OUT_W         = 32;
    localparam int T_W           = 23;
    localparam int PC_W          = 6;
    localparam int RF_AW         = 5;
    localparam int RF_DEPTH      = 32;
    localparam int VEL_SHIFT     = 16;
    localparam int ACC_SHIFT     = 17;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 6'd32;
    localparam logic [PC_W-1:0]   FIT_PC     = 6'd13;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FETCH,
        ST_LOADX,
        ST_LOADY,
        ST_RD,
        ST_EX,
        ST_MUL,
        ST_DABS1,
        ST_DABS2,
        ST_DPREP,
        ST_DIV,
        ST_DFIN,
        ST_OUT
    } state_t;

    typedef enum logic [RF_AW-1:0] {
        R_S1, R_S2, R_S3, R_S4, R_T0, R_T1, R_T2,
        R_BX, R_BY, R_X2, R_X3, R_X4, R_P, R_N,
        R_E2, R_E3, R_E4, R_F1, R_F2, R_W, R_A, R_B, R_C, R_NW, R_BS, R_AS
    } rf_addr_t;

    typedef enum logic [3:0] {
        K_MUL,
        K_ADD,
        K_SUB,
        K_SHL_V,
        K_SHL_A,
        K_LDN,
        K_CHKW,
        K_DIV,
        K_LOOP,
        K_DONE
    } uop_kind_t;

    typedef enum logic [1:0] {
        O_POS,
        O_VEL,
        O_ACC
    } osel_t;

    typedef struct packed {
        uop_kind_t kind;
        rf_addr_t  dst;
        rf_addr_t  a;
        rf_addr_t  b;
        osel_t     osel;
    } uop_t;

    // sample body runs once per window entry, fit section once per item
    function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
        uop_t u;
        u = '{K_DONE, R_P, R_P, R_P, O_POS};
        unique case (pc)
            6'd0:  u = '{K_MUL,   R_X2, R_BX, R_BX, O_POS};
            6'd1:  u = '{K_ADD,   R_S1, R_S1, R_BX, O_POS};
            6'd2:  u = '{K_ADD,   R_S2, R_S2, R_X2, O_POS};
            6'd3:  u = '{K_MUL,   R_X3, R_X2, R_BX, O_POS};
            6'd4:  u = '{K_ADD,   R_S3, R_S3, R_X3, O_POS};
            6'd5:  u = '{K_MUL,   R_X4, R_X3, R_BX, O_POS};
            6'd6:  u = '{K_ADD,   R_S4, R_S4, R_X4, O_POS};
            6'd7:  u = '{K_MUL,   R_P,  R_BY, R_BX, O_POS};
            6'd8:  u = '{K_ADD,   R_T1, R_T1, R_P,  O_POS};
            6'd9:  u = '{K_MUL,   R_P,  R_X2, R_BY, O_POS};
            6'd10: u = '{K_ADD,   R_T2, R_T2, R_P,  O_POS};
            6'd11: u = '{K_ADD,   R_T0, R_T0, R_BY, O_POS};
            6'd12: u = '{K_LOOP,  R_P,  R_P,  R_P,  O_POS};
            6'd13: u = '{K_LDN,   R_N,  R_P,  R_P,  O_POS};
            6'd14: u = '{K_MUL,   R_E2, R_S2, R_N,  O_POS};
            6'd15: u = '{K_MUL,   R_P,  R_S1, R_S1, O_POS};
            6'd16: u = '{K_SUB,   R_E2, R_E2, R_P,  O_POS};
            6'd17: u = '{K_MUL,   R_E3, R_S3, R_N,  O_POS};
            6'd18: u = '{K_MUL,   R_P,  R_S2, R_S1, O_POS};
            6'd19: u = '{K_SUB,   R_E3, R_E3, R_P,  O_POS};
            6'd20: u = '{K_MUL,   R_E4, R_S4, R_N,  O_POS};
            6'd21: u = '{K_MUL,   R_P,  R_S2, R_S2, O_POS};
            6'd22: u = '{K_SUB,   R_E4, R_E4, R_P,  O_POS};
            6'd23: u = '{K_MUL,   R_F1, R_T1, R_N,  O_POS};
            6'd24: u = '{K_MUL,   R_P,  R_T0, R_S1, O_POS};
            6'd25: u = '{K_SUB,   R_F1, R_F1, R_P,  O_POS};
            6'd26: u = '{K_MUL,   R_F2, R_T2, R_N,  O_POS};
            6'd27: u = '{K_MUL,   R_P,  R_S2, R_T0, O_POS};
            6'd28: u = '{K_SUB,   R_F2, R_F2, R_P,  O_POS};
            6'd29: u = '{K_MUL,   R_W,  R_E4, R_E2, O_POS};
            6'd30: u = '{K_MUL,   R_P,  R_E3, R_E3, O_POS};
            6'd31: u = '{K_SUB,   R_W,  R_W,  R_P,  O_POS};
            6'd32: u = '{K_CHKW,  R_P,  R_W,  R_W,  O_POS};
            6'd33: u = '{K_MUL,   R_A,  R_F2, R_E2, O_POS};
            6'd34: u = '{K_MUL,   R_P,  R_F1, R_E3, O_POS};
            6'd35: u = '{K_SUB,   R_A,  R_A,  R_P,  O_POS};
            6'd36: u = '{K_MUL,   R_B,  R_F1, R_E4, O_POS};
            6'd37: u = '{K_MUL,   R_P,  R_F2, R_E3, O_POS};
            6'd38: u = '{K_SUB,   R_B,  R_B,  R_P,  O_POS};
            6'd39: u = '{K_MUL,   R_C,  R_W,  R_T0, O_POS};
            6'd40: u = '{K_MUL,   R_P,  R_B,  R_S1, O_POS};
            6'd41: u = '{K_SUB,   R_C,  R_C,  R_P,  O_POS};
            6'd42: u = '{K_MUL,   R_P,  R_A,  R_S2, O_POS};
            6'd43: u = '{K_SUB,   R_C,  R_C,  R_P,  O_POS};
            6'd44: u = '{K_MUL,   R_NW, R_W,  R_N,  O_POS};
            6'd45: u = '{K_SHL_V, R_BS, R_B,  R_B,  O_POS};
            6'd46: u = '{K_SHL_A, R_AS, R_A,  R_A,  O_POS};
            6'd47: u = '{K_DIV,   R_P,  R_C,  R_NW, O_POS};
            6'd48: u = '{K_DIV,   R_P,  R_BS, R_W,  O_VEL};
            6'd49: u = '{K_DIV,   R_P,  R_AS, R_W,  O_ACC};
            default: u = '{K_DONE, R_P, R_P, R_P, O_POS};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/windowed_quadratic_fit_unit.sv
// Windowed least-squares quadratic fit: sample ring, micro-programmed
// sequencer, bit-serial 256-bit multiplier and divider on a shared register file.
// Depends on wqf_pkg.
//
// channel   dir  handshake              payload
// s_        in   s_tvalid / s_tready    s_tdata: position, interval; s_tuser: opcode
// m_        out  m_tvalid / m_tready    m_tdata: position, velocity, accel; m_tuser: flags
// cfg_      in   cfg_valid / cfg_ready  cfg_data: window length
//
// Restart and not-yet-full items go straight to the output stage. A fit clears its sums,
// runs the sample body once per window entry and then the solve on the bit-serial
// multiplier (one bit per cycle, stops at the multiplier's sign) and three restoring
// divisions; a singular fit stops right after the determinant.
// aresetn clears control state; store contents are undefined until written.
// The input is taken only in idle; a result beat waits in m_tdata while the next
// input beat is taken, and the sequencer stalls before its write if m_ is held.
`default_nettype none

module windowed_quadratic_fit_unit #(
    parameter int STORE_DEPTH = wqf_pkg::STORE_DEPTH_D
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [23:0] position_sample, [39:24] sample_interval
    input  wire logic        s_tuser,   // [0] opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // [31:0] position, [63:32] velocity, [95:64] accel
    output logic [1:0]       m_tuser,   // [0] fit_valid, [1] fit_singular
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_data   // [5:0] window_length
);

    localparam int IW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SEEN_CAP_I = (STORE_DEPTH < 63) ? STORE_DEPTH : 63;
    localparam logic [5:0] SEEN_CAP = 6'(SEEN_CAP_I);
    localparam logic [IW-1:0] LAST_SLOT = IW'(STORE_DEPTH - 1);
    localparam int WD = wqf_pkg::WIDE;

    wqf_pkg::state_t state_reg, state_next;
    wqf_pkg::uop_t   uop;

    logic [5:0]               wlen_reg;
    logic [IW-1:0]            newest_reg, newest_next;
    logic [5:0]               seen_reg, seen_next;
    logic [IW-1:0]            idx_reg, idx_next;
    logic [5:0]               cnt_reg, cnt_next;
    logic [5:0]               len_reg, len_next;
    logic signed [wqf_pkg::T_W-1:0] t_reg, t_next;
    logic [wqf_pkg::PC_W-1:0] pc_reg, pc_next;
    logic [2:0]               clr_reg, clr_next;

    logic [WD-1:0] rda_reg, rdb_reg;
    logic [WD-1:0] md_reg, md_next, mr_reg, mr_next, acc_reg, acc_next;
    logic [WD-1:0] n_reg, n_next, d_reg, d_next, r_reg, r_next;
    logic [31:0]   q_reg, q_next;
    logic          big_reg, big_next, neg_reg, neg_next;
    logic [7:0]    dcnt_reg, dcnt_next;
    wqf_pkg::osel_t osel_reg, osel_next;

    logic [31:0] res_reg [3];
    logic [31:0] res_next [3];
    logic        fv_reg, fv_next, fs_reg, fs_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [95:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    logic [wqf_pkg::POS_W-1:0] pos_mem [STORE_DEPTH];
    logic [wqf_pkg::INT_W-1:0] int_mem [STORE_DEPTH];
    logic [wqf_pkg::POS_W-1:0] pos_rd_reg;
    logic [wqf_pkg::INT_W-1:0] int_rd_reg;
    logic                      st_we;
    logic [IW-1:0]             st_wa;

    logic [WD-1:0] rf_mem [wqf_pkg::RF_DEPTH];
    logic          rf_we;
    wqf_pkg::rf_addr_t rf_wa;
    logic [WD-1:0] rf_wd;

    logic [5:0]    len_now, len_clamp;
    logic          mul_sub;
    logic [WD-1:0] mul_sum;
    logic [WD-1:0] r_sh;
    logic [WD:0]   r_diff;
    logic [31:0]   lim, mag;
    logic          accept;

    assign uop       = wqf_pkg::uop_at(pc_reg);
    assign s_tready  = (state_reg == wqf_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign len_clamp = (wlen_reg == 6'd0) ? 6'd1 : wlen_reg;
    assign len_now   = (len_clamp > SEEN_CAP) ? SEEN_CAP : len_clamp;

    assign mul_sub = &mr_reg;
    assign mul_sum = acc_reg + (mul_sub ? ~md_reg : md_reg) + {{(WD-1){1'b0}}, mul_sub};

    assign r_sh   = {r_reg[WD-2:0], n_reg[WD-1]};
    assign r_diff = {1'b0, r_sh} - {1'b0, d_reg};
    assign lim    = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign mag    = (big_reg || (q_reg > lim)) ? lim : q_reg;

    always_ff @(posedge aclk) begin
        if (st_we) begin
            pos_mem[st_wa] <= s_tdata[23:0];
            int_mem[st_wa] <= s_tdata[39:24];
        end
        pos_rd_reg <= pos_mem[idx_reg];
        int_rd_reg <= int_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[rf_wa] <= rf_wd;
        end
        rda_reg <= rf_mem[uop.a];
        rdb_reg <= rf_mem[uop.b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wqf_pkg::ST_IDLE;
            wlen_reg     <= wqf_pkg::WLEN_RESET;
            newest_reg   <= '0;
            seen_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            newest_reg   <= newest_next;
            seen_reg     <= seen_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                wlen_reg <= cfg_data;
            end
        end
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        len_reg     <= len_next;
        t_reg       <= t_next;
        pc_reg      <= pc_next;
        clr_reg     <= clr_next;
        md_reg      <= md_next;
        mr_reg      <= mr_next;
        acc_reg     <= acc_next;
        n_reg       <= n_next;
        d_reg       <= d_next;
        r_reg       <= r_next;
        q_reg       <= q_next;
        big_reg     <= big_next;
        neg_reg     <= neg_next;
        dcnt_reg    <= dcnt_next;
        osel_reg    <= osel_next;
        res_reg     <= res_next;
        fv_reg      <= fv_next;
        fs_reg      <= fs_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_comb begin
        state_next    = state_reg;
        newest_next   = newest_reg;
        seen_next     = seen_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        len_next      = len_reg;
        t_next        = t_reg;
        pc_next       = pc_reg;
        clr_next      = clr_reg;
        md_next       = md_reg;
        mr_next       = mr_reg;
        acc_next      = acc_reg;
        n_next        = n_reg;
        d_next        = d_reg;
        r_next        = r_reg;
        q_next        = q_reg;
        big_next      = big_reg;
        neg_next      = neg_reg;
        dcnt_next     = dcnt_reg;
        osel_next     = osel_reg;
        res_next      = res_reg;
        fv_next       = fv_reg;
        fs_next       = fs_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        st_we         = 1'b0;
        st_wa         = newest_reg;
        rf_we         = 1'b0;
        rf_wa         = uop.dst;
        rf_wd         = '0;

        unique case (state_reg)
            wqf_pkg::ST_IDLE: begin
                if (accept) begin
                    res_next[0] = '0;
                    res_next[1] = '0;
                    res_next[2] = '0;
                    fv_next     = 1'b0;
                    fs_next     = 1'b0;
                    state_next  = wqf_pkg::ST_OUT;
                    if (s_tuser) begin
                        seen_next   = '0;
                        newest_next = '0;
                    end else begin
                        newest_next = (newest_reg == LAST_SLOT) ? '0 : newest_reg + IW'(1);
                        st_we       = 1'b1;
                        st_wa       = newest_next;
                        if (seen_reg < SEEN_CAP) begin
                            seen_next = seen_reg + 6'd1;
                        end
                        if (seen_next >= len_now) begin
                            idx_next   = newest_next;
                            len_next   = len_now;
                            cnt_next   = '0;
                            t_next     = '0;
                            clr_next   = '0;
                            pc_next    = '0;
                            state_next = wqf_pkg::ST_CLEAR;
                        end
                    end
                end
            end
            wqf_pkg::ST_CLEAR: begin
                rf_we    = 1'b1;
                rf_wa    = wqf_pkg::rf_addr_t'({2'b00, clr_reg});
                rf_wd    = '0;
                clr_next = clr_reg + 3'd1;
                if (clr_reg == 3'd6) begin
                    state_next = wqf_pkg::ST_FETCH;
                end
            end
            wqf_pkg::ST_FETCH: begin
                state_next = wqf_pkg::ST_LOADX;
            end
            wqf_pkg::ST_LOADX: begin
                rf_we      = 1'b1;
                rf_wa      = wqf_pkg::R_BX;
                rf_wd      = WD'(t_reg);
                state_next = wqf_pkg::ST_LOADY;
            end
            wqf_pkg::ST_LOADY: begin
                rf_we      = 1'b1;
                rf_wa      = wqf_pkg::R_BY;
                rf_wd      = WD'($signed(pos_rd_reg));
                state_next = wqf_pkg::ST_RD;
            end
            wqf_pkg::ST_RD: begin
                state_next = wqf_pkg::ST_EX;
            end
            wqf_pkg::ST_EX: begin
                pc_next    = pc_reg + 6'd1;
                state_next = wqf_pkg::ST_RD;
                unique case (uop.kind)
                    wqf_pkg::K_MUL: begin
                        md_next    = rda_reg;
                        mr_next    = rdb_reg;
                        acc_next   = '0;
                        pc_next    = pc_reg;
                        state_next = wqf_pkg::ST_MUL;
                    end
                    wqf_pkg::K_ADD: begin
                        rf_we = 1'b1;
                        rf_wd = rda_reg + rdb_reg;
                    end
                    wqf_pkg::K_SUB: begin
                        rf_we = 1'b1;
                        rf_wd = rda_reg - rdb_reg;
                    end
                    wqf_pkg::K_SHL_V: begin
                        rf_we = 1'b1;
                        rf_wd = rda_reg << wqf_pkg::VEL_SHIFT;
                    end
                    wqf_pkg::K_SHL_A: begin
                        rf_we = 1'b1;
                        rf_wd = rda_reg << wqf_pkg::ACC_SHIFT;
                    end
                    wqf_pkg::K_LDN: begin
                        rf_we = 1'b1;
                        rf_wd = WD'(len_reg);
                    end
                    wqf_pkg::K_CHKW: begin
                        if (rda_reg == '0) begin
                            fv_next    = 1'b1;
                            fs_next    = 1'b1;
                            state_next = wqf_pkg::ST_OUT;
                        end
                    end
                    wqf_pkg::K_DIV: begin
                        n_next     = rda_reg;
                        d_next     = rdb_reg;
                        neg_next   = rda_reg[WD-1] ^ rdb_reg[WD-1];
                        osel_next  = uop.osel;
                        pc_next    = pc_reg;
                        state_next = wqf_pkg::ST_DABS1;
                    end
                    wqf_pkg::K_LOOP: begin
                        t_next = t_reg - wqf_pkg::T_W'(int_rd_reg);
                        if (cnt_reg == len_reg - 6'd1) begin
                            pc_next = wqf_pkg::FIT_PC;
                        end else begin
                            cnt_next   = cnt_reg + 6'd1;
                            idx_next   = (idx_reg == '0) ? LAST_SLOT : idx_reg - IW'(1);
                            pc_next    = '0;
                            state_next = wqf_pkg::ST_FETCH;
                        end
                    end
                    wqf_pkg::K_DONE: begin
                        fv_next    = 1'b1;
                        fs_next    = 1'b0;
                        state_next = wqf_pkg::ST_OUT;
                    end
                    default: begin
                        state_next = wqf_pkg::ST_OUT;
                    end
                endcase
            end
            wqf_pkg::ST_MUL: begin
                if ((mr_reg == '0) || mul_sub) begin
                    rf_we      = 1'b1;
                    rf_wd      = mul_sub ? mul_sum : acc_reg;
                    pc_next    = pc_reg + 6'd1;
                    state_next = wqf_pkg::ST_RD;
                end else begin
                    if (mr_reg[0]) begin
                        acc_next = mul_sum;
                    end
                    md_next = md_reg << 1;
                    mr_next = {mr_reg[WD-1], mr_reg[WD-1:1]};
                end
            end
            wqf_pkg::ST_DABS1: begin
                n_next     = n_reg[WD-1] ? (~n_reg + WD'(1)) : n_reg;
                state_next = wqf_pkg::ST_DABS2;
            end
            wqf_pkg::ST_DABS2: begin
                d_next     = d_reg[WD-1] ? (~d_reg + WD'(1)) : d_reg;
                state_next = wqf_pkg::ST_DPREP;
            end
            wqf_pkg::ST_DPREP: begin
                n_next     = {n_reg[WD-2:0], 1'b0} + d_reg;
                d_next     = {d_reg[WD-2:0], 1'b0};
                r_next     = '0;
                q_next     = '0;
                big_next   = 1'b0;
                dcnt_next  = 8'hFF;
                state_next = wqf_pkg::ST_DIV;
            end
            wqf_pkg::ST_DIV: begin
                r_next    = r_diff[WD] ? r_sh : r_diff[WD-1:0];
                q_next    = {q_reg[30:0], ~r_diff[WD]};
                big_next  = big_reg | q_reg[31];
                n_next    = {n_reg[WD-2:0], 1'b0};
                dcnt_next = dcnt_reg - 8'd1;
                if (dcnt_reg == 8'd0) begin
                    state_next = wqf_pkg::ST_DFIN;
                end
            end
            wqf_pkg::ST_DFIN: begin
                res_next[osel_reg] = neg_reg ? (32'd0 - mag) : mag;
                pc_next            = pc_reg + 6'd1;
                state_next         = wqf_pkg::ST_RD;
            end
            wqf_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_reg[2], res_reg[1], res_reg[0]};
                    m_tuser_next  = {fs_reg, fv_reg};
                    state_next    = wqf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wqf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
